/* hw/rtl/weighted_manhattan_voronoi_labeler_assert.svh */
// Assertion macros shared by the labeler RTL
`ifndef WEIGHTED_MANHATTAN_VORONOI_LABELER_ASSERT_SVH
`define WEIGHTED_MANHATTAN_VORONOI_LABELER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WMVL_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WMVL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wmvl_pkg.sv */
// Types and constants shared by the labeler modules
`timescale 1ns / 1ps
package wmvl_pkg;

    localparam int COORD_W  = 10;
    localparam int WEIGHT_W = 10;
    localparam int LABEL_W  = 5;
    localparam int EXTENT_W = 11;
    localparam int DIST_W   = COORD_W + 1;
    localparam int PROD_W   = DIST_W + WEIGHT_W;

    localparam logic [EXTENT_W-1:0] EXTENT_RESET = EXTENT_W'(900);

    // Request codes carried in req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [LABEL_W-1:0]  t_label;
    typedef logic [EXTENT_W-1:0] t_extent;
    typedef logic [DIST_W-1:0]   t_dist;
    typedef logic [PROD_W-1:0]   t_prod;

    typedef struct packed {
        t_coord  x;
        t_coord  y;
        t_weight w;
    } t_seed;

    typedef struct packed {
        logic load;    // write seed slot, clear its edge flag
        logic start;   // capture pixel, read row buffer
        logic issue;   // read next seed into the distance pipe
        logic finish;  // form result, update row buffer and flags
    } t_cmd;

    typedef struct packed {
        logic last_issue;
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/wmvl_req_if.sv */
// Request channel: seed loads and pixel requests
`timescale 1ns / 1ps
interface wmvl_req_if;
    import wmvl_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    t_label seed_index;
    t_coord seed_x;
    t_coord seed_y;
    t_weight seed_weight;
    t_coord pixel_x;
    t_coord pixel_y;

    modport source (
        output valid, req_type, seed_index, seed_x, seed_y, seed_weight,
               pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, seed_index, seed_x, seed_y, seed_weight,
               pixel_x, pixel_y,
        output ready
    );
endinterface

/* hw/rtl/wmvl_res_if.sv */
// Result channel: one label record per pixel
`timescale 1ns / 1ps
interface wmvl_res_if #(
    parameter int NUM_SEEDS = 20
);
    import wmvl_pkg::*;

    logic   valid;
    logic   ready;
    t_label label;
    t_label left_label;
    t_label up_label;
    logic   on_border;
    logic [NUM_SEEDS-1:0] edge_seed_mask;

    modport source (
        output valid, label, left_label, up_label, on_border, edge_seed_mask,
        input  ready
    );
    modport sink (
        input  valid, label, left_label, up_label, on_border, edge_seed_mask,
        output ready
    );
endinterface

/* hw/rtl/wmvl_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module wmvl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/wmvl_ctrl.sv */
// Sequencer for seed loads and the per-pixel seed scan
`timescale 1ns / 1ps
module wmvl_ctrl
    import wmvl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_req_type,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    `include "weighted_manhattan_voronoi_labeler_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load  = accept && (i_req_type == REQ_LOAD);
                o_cmd.start = accept && (i_req_type == REQ_PIXEL);
                if (o_cmd.start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold the result until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `WMVL_ASSERT_SAME(a_done_in_drain, i_clk, i_rst_n, i_sts.scan_done, r_state == S_DRAIN,
        "last compare seen outside drain")
    `WMVL_ASSERT_SAME(a_finish_pipe_empty, i_clk, i_rst_n, r_state == S_FINISH, !i_sts.pipe_busy,
        "distance pipe still busy at finish")
endmodule

/* hw/rtl/wmvl_datapath.sv */
// Seed store, distance pipeline, row buffer and result register
`timescale 1ns / 1ps
module wmvl_datapath
    import wmvl_pkg::*;
#(
    parameter int NUM_SEEDS    = 20,
    parameter int MAX_MAP_SIZE = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  t_extent              i_cfg_wdata,
    input  t_label               i_seed_index,
    input  t_coord               i_seed_x,
    input  t_coord               i_seed_y,
    input  t_weight              i_seed_weight,
    input  t_coord               i_pixel_x,
    input  t_coord               i_pixel_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_label               o_label,
    output t_label               o_left_label,
    output t_label               o_up_label,
    output logic                 o_on_border,
    output logic [NUM_SEEDS-1:0] o_edge_seed_mask
);
    `include "weighted_manhattan_voronoi_labeler_assert.svh"

    localparam int SAW = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;
    localparam int RAW = (MAX_MAP_SIZE > 1) ? $clog2(MAX_MAP_SIZE) : 1;
    localparam t_label LAST_SEED = LABEL_W'(NUM_SEEDS - 1);

    // configuration
    t_extent r_map_extent;

    // pixel context
    t_coord r_px;
    t_coord r_py;

    // scan pipeline
    t_label r_issue_idx;
    logic   r_v1, r_v2, r_v3;
    t_label r_tag1, r_tag2, r_tag3;
    t_dist  r_dist;
    t_weight r_w;
    t_prod  r_prod;
    t_prod  r_best_d;
    t_label r_best;

    // running label state
    t_label                r_prev_label;
    logic [NUM_SEEDS-1:0]  r_edge_flags;
    logic [NUM_SEEDS-1:0]  n_edge_flags;

    // result register
    logic                  r_out_valid;
    t_label                r_out_label;
    t_label                r_out_left;
    t_label                r_out_up;
    logic                  r_out_border;
    logic [NUM_SEEDS-1:0]  r_out_mask;

    logic       seed_ok;
    t_seed      seed_wdata;
    t_seed      seed_rdata;
    t_label     row_rdata;
    t_coord     dx, dy;
    t_dist      dsum;
    t_extent    last_line;
    logic       on_edge;
    t_label     left_lbl;
    t_label     up_lbl;
    logic       border;

    assign seed_ok    = {1'b0, i_seed_index} < (LABEL_W + 1)'(NUM_SEEDS);
    assign seed_wdata = '{x: i_seed_x, y: i_seed_y, w: i_seed_weight};

    wmvl_ram #(
        .WIDTH ($bits(t_seed)),
        .DEPTH (NUM_SEEDS)
    ) u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && seed_ok),
        .i_waddr (i_seed_index[SAW-1:0]),
        .i_wdata (seed_wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (r_issue_idx[SAW-1:0]),
        .o_rdata (seed_rdata)
    );

    // row buffer: read at pixel start, written with the new label at finish
    wmvl_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAX_MAP_SIZE)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr (RAW'(r_px)),
        .i_wdata (r_best),
        .i_re    (i_cmd.start),
        .i_raddr (RAW'(i_pixel_x)),
        .o_rdata (row_rdata)
    );

    // stage 1: Manhattan distance from the seed just read
    assign dx   = (r_px >= seed_rdata.x) ? (r_px - seed_rdata.x) : (seed_rdata.x - r_px);
    assign dy   = (r_py >= seed_rdata.y) ? (r_py - seed_rdata.y) : (seed_rdata.y - r_py);
    assign dsum = DIST_W'(dx) + DIST_W'(dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px        <= i_pixel_x;
            r_py        <= i_pixel_y;
            r_issue_idx <= '0;
        end else if (i_cmd.issue) begin
            r_issue_idx <= r_issue_idx + LABEL_W'(1);
        end
        r_tag1 <= r_issue_idx;
        r_tag2 <= r_tag1;
        r_dist <= dsum;
        r_w    <= seed_rdata.w;
        r_tag3 <= r_tag2;
        r_prod <= PROD_W'(r_dist) * PROD_W'(r_w);
        // strict compare in index order keeps the lower index on a tie
        if (r_v3 && ((r_tag3 == '0) || (r_prod < r_best_d))) begin
            r_best_d <= r_prod;
            r_best   <= r_tag3;
        end
    end

    assign last_line = r_map_extent - EXTENT_W'(1);
    assign on_edge   = (r_px == '0) || (r_py == '0) ||
                       ({1'b0, r_px} == last_line) || ({1'b0, r_py} == last_line);
    assign left_lbl  = (r_px != '0) ? r_prev_label : '0;
    assign up_lbl    = (r_py != '0) ? row_rdata : '0;
    assign border    = (r_px != '0) && (r_py != '0) &&
                       ((left_lbl != r_best) || (up_lbl != r_best));

    always_comb begin
        n_edge_flags = r_edge_flags;
        for (int i = 0; i < NUM_SEEDS; i++) begin
            if (i_cmd.load && seed_ok && (i_seed_index == LABEL_W'(i))) begin
                n_edge_flags[i] = 1'b0;
            end
            if (i_cmd.finish && on_edge && (r_best == LABEL_W'(i))) begin
                n_edge_flags[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_extent <= EXTENT_RESET;
            r_prev_label <= '0;
            r_edge_flags <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_map_extent <= i_cfg_wdata;
            end
            r_edge_flags <= n_edge_flags;
            if (i_cmd.finish) begin
                r_prev_label <= r_best;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_label  <= r_best;
            r_out_left   <= left_lbl;
            r_out_up     <= up_lbl;
            r_out_border <= border;
            r_out_mask   <= n_edge_flags;
        end
    end

    assign o_sts.last_issue = (r_issue_idx == LAST_SEED);
    assign o_sts.scan_done  = r_v3 && (r_tag3 == LAST_SEED);
    assign o_sts.pipe_busy  = r_v1 || r_v2 || r_v3;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_label          = r_out_label;
    assign o_left_label     = r_out_left;
    assign o_up_label       = r_out_up;
    assign o_on_border      = r_out_border;
    assign o_edge_seed_mask = r_out_mask;

    `WMVL_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, i_cmd.finish,
        !r_out_valid || i_out_ready, "pending result overwritten")
    `WMVL_ASSERT_SAME(a_label_range, i_clk, i_rst_n, r_out_valid,
        {1'b0, r_out_label} < (LABEL_W + 1)'(NUM_SEEDS), "label beyond seed count")
    `WMVL_ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, i_cmd.finish,
        r_out_valid && (r_prev_label == r_out_label), "result or previous label not updated")
endmodule

/* hw/rtl/weighted_manhattan_voronoi_labeler.sv */
// Weighted Manhattan Voronoi labeler: top level
//
// Request channel i_req carries two kinds of transaction. A seed load
// (req_type 0) writes slot seed_index with x, y and a Q2.8 weight and
// clears that seed's edge flag; it gives no result.
// A pixel request (req_type 1) is labeled with the seed of least
// (|dx|+|dy|)*weight, lower index on a tie, and gives one transaction on
// o_res with the label, left and upper neighbor labels, border flag and
// the mask of seeds that own a map-edge pixel.
// A pixel scans the seeds one per cycle through a single distance and
// multiply pipe; the next request is taken only once its result is
// formed. The map side length is written through i_cfg_we/i_cfg_wdata;
// the user must write it only while idle, which the block does not enforce.
// Reset sets the side length to 900 and clears the edge flags and the
// previous label; seed slots and the row buffer hold nothing until
// written. A result waits in the output register while the receiver
// stalls; a following request is still taken and its scan runs, then
// holds until the register is free.
`timescale 1ns / 1ps
module weighted_manhattan_voronoi_labeler
    import wmvl_pkg::*;
#(
    parameter int NUM_SEEDS    = 20,
    parameter int MAX_MAP_SIZE = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wmvl_req_if.sink          i_req,
    wmvl_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [EXTENT_W-1:0] i_cfg_wdata
);
    t_cmd cmd;
    t_sts sts;

    wmvl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_req_type (i_req.req_type),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    wmvl_datapath #(
        .NUM_SEEDS    (NUM_SEEDS),
        .MAX_MAP_SIZE (MAX_MAP_SIZE)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_seed_index     (i_req.seed_index),
        .i_seed_x         (i_req.seed_x),
        .i_seed_y         (i_req.seed_y),
        .i_seed_weight    (i_req.seed_weight),
        .i_pixel_x        (i_req.pixel_x),
        .i_pixel_y        (i_req.pixel_y),
        .o_out_valid      (o_res.valid),
        .i_out_ready      (o_res.ready),
        .o_label          (o_res.label),
        .o_left_label     (o_res.left_label),
        .o_up_label       (o_res.up_label),
        .o_on_border      (o_res.on_border),
        .o_edge_seed_mask (o_res.edge_seed_mask)
    );
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the weighted Manhattan Voronoi labeler
`timescale 1ns / 1ps
module testbench;
    import wmvl_pkg::*;

    localparam int NUM_SEEDS     = 20;
    localparam int MAP_SIZE      = 1024;
    localparam int ITEM_TARGET   = 1550;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic    kind;
        t_label  idx;
        t_coord  sx;
        t_coord  sy;
        t_weight sw;
        t_coord  px;
        t_coord  py;
    } t_req_item;

    typedef struct {
        t_label               label;
        t_label               left_label;
        t_label               up_label;
        logic                 on_border;
        logic [NUM_SEEDS-1:0] edge_mask;
    } t_label_rec;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_cfg_we;
    t_extent i_cfg_wdata;

    wmvl_req_if req_ch ();
    wmvl_res_if #(.NUM_SEEDS(NUM_SEEDS)) res_ch ();

    weighted_manhattan_voronoi_labeler #(
        .NUM_SEEDS    (NUM_SEEDS),
        .MAX_MAP_SIZE (MAP_SIZE)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Request backlog and expected label records
    t_req_item  stim_backlog[$];
    t_label_rec expected_labels[$];
    t_req_item  on_wire;

    // Mirror of the block state
    t_seed                seed_tab[NUM_SEEDS];
    t_label               row_labels[MAP_SIZE];
    t_label               prev_label;
    logic [NUM_SEEDS-1:0] edge_bits;
    t_extent              extent_now;

    // Generator bookkeeping
    bit col_seen[MAP_SIZE];
    int stim_count;
    int fail_count;
    int sender_gap_max;
    int receiver_stall_max;
    int gap_left;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Update the mirror with one accepted transaction; queue a label record for pixels
    function automatic void nearest_seed_update(input t_req_item r);
        t_label_rec rec;
        t_label     best;
        t_prod      best_d;
        t_prod      d;
        t_coord     dx;
        t_coord     dy;
        t_extent    last;
        if (r.kind == REQ_LOAD) begin
            if (int'(r.idx) < NUM_SEEDS) begin
                seed_tab[r.idx] = '{x: r.sx, y: r.sy, w: r.sw};
                edge_bits[r.idx] = 1'b0;
            end
            return;
        end
        best   = '0;
        best_d = '0;
        for (int k = 0; k < NUM_SEEDS; k++) begin
            dx = (r.px > seed_tab[k].x) ? r.px - seed_tab[k].x : seed_tab[k].x - r.px;
            dy = (r.py > seed_tab[k].y) ? r.py - seed_tab[k].y : seed_tab[k].y - r.py;
            d  = t_prod'(t_dist'(dx) + t_dist'(dy)) * t_prod'(seed_tab[k].w);
            // strict compare keeps the lower index on a tie
            if (k == 0 || d < best_d) begin
                best_d = d;
                best   = t_label'(k);
            end
        end
        last = extent_now - 1'b1;
        if (r.px == 0 || r.py == 0 || t_extent'(r.px) == last || t_extent'(r.py) == last)
            edge_bits[best] = 1'b1;
        rec.label      = best;
        rec.left_label = (r.px != 0) ? prev_label : '0;
        rec.up_label   = (r.py != 0) ? row_labels[r.px] : '0;
        rec.on_border  = (r.px != 0 && r.py != 0 &&
                          (rec.left_label != best || rec.up_label != best));
        rec.edge_mask  = edge_bits;
        row_labels[r.px] = best;
        prev_label       = best;
        expected_labels.push_back(rec);
    endfunction

    // Request driver
    always @(posedge i_clk) begin : drive_req
        logic next_valid;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                nearest_seed_update(on_wire);
                gap_left   = $urandom_range(0, sender_gap_max);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_backlog.size() != 0) begin
                    on_wire = stim_backlog.pop_front();
                    req_ch.req_type    <= on_wire.kind;
                    req_ch.seed_index  <= on_wire.idx;
                    req_ch.seed_x      <= on_wire.sx;
                    req_ch.seed_y      <= on_wire.sy;
                    req_ch.seed_weight <= on_wire.sw;
                    req_ch.pixel_x     <= on_wire.px;
                    req_ch.pixel_y     <= on_wire.py;
                    next_valid = 1'b1;
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : watch_res
        t_label_rec want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_labels.size() == 0) begin
                    $error("unexpected result transaction: label %0d", res_ch.label);
                    fail_count++;
                end else begin
                    want = expected_labels.pop_front();
                    if (res_ch.label !== want.label) begin
                        $error("label: expected %0d, got %0d", want.label, res_ch.label);
                        fail_count++;
                    end
                    if (res_ch.left_label !== want.left_label) begin
                        $error("left_label: expected %0d, got %0d",
                               want.left_label, res_ch.left_label);
                        fail_count++;
                    end
                    if (res_ch.up_label !== want.up_label) begin
                        $error("up_label: expected %0d, got %0d",
                               want.up_label, res_ch.up_label);
                        fail_count++;
                    end
                    if (res_ch.on_border !== want.on_border) begin
                        $error("on_border: expected %0d, got %0d",
                               want.on_border, res_ch.on_border);
                        fail_count++;
                    end
                    if (res_ch.edge_seed_mask !== want.edge_mask) begin
                        $error("edge_seed_mask: expected %h, got %h",
                               want.edge_mask, res_ch.edge_seed_mask);
                        fail_count++;
                    end
                end
                hold_left = $urandom_range(0, receiver_stall_max);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            res_ch.ready <= (hold_left == 0);
        end
    end

    task automatic queue_load(input int idx, input int x, input int y, input int w);
        t_req_item r;
        r = '{kind: REQ_LOAD, idx: t_label'(idx), sx: t_coord'(x), sy: t_coord'(y),
              sw: t_weight'(w), px: t_coord'($urandom), py: t_coord'($urandom)};
        stim_backlog.push_back(r);
        if (idx < NUM_SEEDS)
            stim_count++;
    endtask

    task automatic queue_pixel(input int x, input int y);
        t_req_item r;
        // never read a row buffer column that was not written yet
        if (y != 0 && !col_seen[x])
            y = 0;
        col_seen[x] = 1'b1;
        r = '{kind: REQ_PIXEL, idx: t_label'($urandom), sx: t_coord'($urandom),
              sy: t_coord'($urandom), sw: t_weight'($urandom),
              px: t_coord'(x), py: t_coord'(y)};
        stim_backlog.push_back(r);
        stim_count++;
    endtask

    // Seed placed inside an n x n map most of the time
    task automatic queue_random_load(input int n);
        int idx;
        int x;
        int y;
        int w;
        int pick;
        idx  = ($urandom_range(0, 7) == 0) ? $urandom_range(NUM_SEEDS, 31)
                                           : $urandom_range(0, NUM_SEEDS - 1);
        x    = ($urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 1023);
        y    = ($urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 1023);
        pick = $urandom_range(0, 39);
        if (pick == 0)
            w = 0;
        else if (pick < 4)
            w = 1023;
        else if (pick < 20)
            w = 256;
        else
            w = $urandom_range(1, 1023);
        queue_load(idx, x, y, w);
    endtask

    // Raster scan of an n x n window, x fastest, with an occasional seed reload
    task automatic queue_scan(input int n);
        int ox;
        int oy;
        bit cols_ready;
        ox = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAP_SIZE - n) : 0;
        cols_ready = 1'b1;
        for (int i = 0; i < n; i++)
            if (!col_seen[ox + i])
                cols_ready = 1'b0;
        oy = (cols_ready && $urandom_range(0, 2) == 0) ? $urandom_range(0, MAP_SIZE - n) : 0;
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 24) == 0)
                    queue_random_load(n);
                queue_pixel(ox + i, oy + j);
            end
        end
    endtask

    // Hold until every transaction is through, then let the block settle
    task automatic wait_idle();
        while (stim_backlog.size() != 0 || req_ch.valid || expected_labels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_extent(input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t_extent'(value);
        @(posedge i_clk);
        extent_now = t_extent'(value);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int phase;
        int n;
        int ext;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOAD;
        req_ch.seed_index  = '0;
        req_ch.seed_x      = '0;
        req_ch.seed_y      = '0;
        req_ch.seed_weight = '0;
        req_ch.pixel_x     = '0;
        req_ch.pixel_y     = '0;
        res_ch.ready       = 1'b0;
        for (int k = 0; k < NUM_SEEDS; k++)
            seed_tab[k] = '0;
        for (int c = 0; c < MAP_SIZE; c++) begin
            row_labels[c] = '0;
            col_seen[c]   = 1'b0;
        end
        prev_label         = '0;
        edge_bits          = '0;
        extent_now         = EXTENT_RESET;
        stim_count         = 0;
        fail_count         = 0;
        sender_gap_max     = 15;
        receiver_stall_max = 15;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: corner seeds, a duplicate seed for the tie rule, ignored slots
        queue_load(0, 0, 0, 1023);
        queue_load(1, 1023, 1023, 1023);
        queue_load(2, 1023, 0, 256);
        queue_load(3, 0, 1023, 256);
        queue_load(4, 500, 500, 1);
        for (int k = 5; k < NUM_SEEDS; k++)
            queue_load(k, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(1, 1023));
        queue_load(NUM_SEEDS, 0, 0, 0);
        queue_load(31, 0, 0, 0);
        queue_load(7, 300, 200, 512);
        queue_load(8, 300, 200, 512);
        queue_pixel(0, 0);
        queue_pixel(1, 0);
        queue_pixel(1023, 0);
        queue_pixel(0, 1023);
        queue_pixel(1, 1);
        queue_pixel(1023, 1023);
        queue_pixel(300, 0);
        queue_pixel(300, 200);

        phase = 0;
        while (stim_count < ITEM_TARGET) begin
            wait_idle();
            // some phases run with no idling on either side
            sender_gap_max     = (phase % 4 == 1) ? 0 : 15;
            receiver_stall_max = (phase % 5 == 2) ? 0 : 15;
            n = $urandom_range(2, 12);
            case (phase)
                0:       ext = 2;
                1:       ext = 1024;
                2:       ext = 0;
                3:       ext = 2047;
                default: ext = ($urandom_range(0, 3) != 0) ? n : $urandom_range(0, 2047);
            endcase
            write_extent(ext);
            repeat ($urandom_range(0, 6))
                queue_random_load(n);
            queue_scan(n);
            // scattered pixels, in no order
            repeat ($urandom_range(0, 12))
                queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            phase++;
        end

        wait_idle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* weighted_manhattan_voronoi_labeler.f */
+incdir+hw/rtl
hw/rtl/wmvl_pkg.sv
hw/rtl/wmvl_req_if.sv
hw/rtl/wmvl_res_if.sv
hw/rtl/wmvl_ram.sv
hw/rtl/wmvl_ctrl.sv
hw/rtl/wmvl_datapath.sv
hw/rtl/weighted_manhattan_voronoi_labeler.sv
sim/testbench.sv
